@@ rtl/core/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DATA_W     = 16;   // Q2.14 word
    localparam int SUM_W      = 18;   // exact trace / diagonal differences
    localparam int S_W        = 17;   // root argument, always positive
    localparam int PAIR_W     = 17;   // off-diagonal sum or difference
    localparam int ROOT_W     = 16;   // integer square root of s << 14
    localparam int SQ_REM_W   = 19;   // square root partial remainder
    localparam int BIGV_W     = 16;   // rounded root value
    localparam int FIFO_DEPTH = 4;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int ONE_Q14    = 16384;
    localparam int Q_MAX      = 32767;
    localparam int Q_NEG_MAG  = 32768;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
        logic signed [DATA_W-1:0] qw;
    } quat_t;

    // which component carries the root
    typedef enum logic [1:0] {
        PICK_W = 2'd0,
        PICK_X = 2'd1,
        PICK_Y = 2'd2,
        PICK_Z = 2'd3
    } pick_t;

    // classified item handed from front to back
    typedef struct packed {
        pick_t                         pick;
        logic [S_W-1:0]                s;
        logic [3:0][PAIR_W-1:0]        pr;   // pair per output slot, qx first
    } job_t;

    // output slot that takes the root for a given pick
    function automatic logic [1:0] root_slot(input pick_t p);
        logic [1:0] r;
        case (p)
            PICK_W:  r = 2'd3;
            PICK_X:  r = 2'd0;
            PICK_Y:  r = 2'd1;
            PICK_Z:  r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/rmq_in_if.sv @@
// ----------------------------------------------------------------------------
// rmq_in_if
// Valid/ready channel carrying one 3x3 matrix.
// ----------------------------------------------------------------------------
interface rmq_in_if
    import rmq_pkg::*;
;
    logic valid;
    logic ready;
    mat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rmq_out_if.sv @@
// ----------------------------------------------------------------------------
// rmq_out_if
// Valid/ready channel carrying one quaternion.
// ----------------------------------------------------------------------------
interface rmq_out_if
    import rmq_pkg::*;
;
    logic  valid;
    logic  ready;
    quat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q2.14 rotation matrix to a Q2.14 quaternion (Shepperd).
// ----------------------------------------------------------------------------
// Usage:
//   mat  : valid/ready sink, one whole 3x3 matrix per transfer.
//   quat : valid/ready source, one quaternion (qx, qy, qz, qw) per transfer.
//   Every matrix gives exactly one quaternion, in order.
// Throughput: one matrix per cycle sustained while quat.ready is held high.
// Path: queue write on the transfer edge, then 16 square root stages,
//   COEF_WIDTH divider stages, multiply stage and result register.
// The front classifies into a 4-entry queue; the back pipeline stalls as a
//   whole while the result register holds an untaken result, and mat.ready
//   stays high until the queue fills.
// Reset clears the queue and all pipeline valid flags; no results are
//   pending after reset and mat.ready is high.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    rmq_in_if.sink    mat,
    rmq_out_if.source quat
);

    logic q_full, q_empty, push, pop;
    job_t push_job, head;

    // classify incoming matrices
    rmq_front u_front (
        .mat    (mat),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    // decoupling queue
    rmq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // root, reciprocal and scaling pipeline
    rmq_back #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .quat    (quat)
    );

endmodule

@@ rtl/core/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Accepts matrices, picks the largest of trace and diagonal differences,
// and forms the root argument and the off-diagonal pairs per output slot.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
(
    rmq_in_if.sink  mat,
    input  logic    q_full,
    output logic    push,
    output job_t    job
);

    logic signed [SUM_W-1:0]  tw, tx, ty, tz, big, s_full;
    logic signed [PAIR_W-1:0] d12, d20, d01, s01, s02, s12;
    pick_t                    pick;

    // accept whenever the queue has room
    assign mat.ready = !q_full;
    assign push      = mat.valid && !q_full;

    // trace and diagonal differences
    always_comb
    begin
        tw = SUM_W'(mat.data.m00) + SUM_W'(mat.data.m11) + SUM_W'(mat.data.m22);
        tx = SUM_W'(mat.data.m00) - SUM_W'(mat.data.m11) - SUM_W'(mat.data.m22);
        ty = SUM_W'(mat.data.m11) - SUM_W'(mat.data.m00) - SUM_W'(mat.data.m22);
        tz = SUM_W'(mat.data.m22) - SUM_W'(mat.data.m00) - SUM_W'(mat.data.m11);
    end

    // largest wins, ties to the earlier of w, x, y, z
    always_comb
    begin
        big  = tw;
        pick = PICK_W;
        if (tx > big)
        begin
            big  = tx;
            pick = PICK_X;
        end
        if (ty > big)
        begin
            big  = ty;
            pick = PICK_Y;
        end
        if (tz > big)
        begin
            big  = tz;
            pick = PICK_Z;
        end
        s_full = big + SUM_W'(ONE_Q14);
        if (s_full <= 0)
        begin
            s_full = SUM_W'(1);
        end
    end

    // off-diagonal pairs
    always_comb
    begin
        d12 = PAIR_W'(mat.data.m12) - PAIR_W'(mat.data.m21);
        d20 = PAIR_W'(mat.data.m20) - PAIR_W'(mat.data.m02);
        d01 = PAIR_W'(mat.data.m01) - PAIR_W'(mat.data.m10);
        s01 = PAIR_W'(mat.data.m01) + PAIR_W'(mat.data.m10);
        s02 = PAIR_W'(mat.data.m20) + PAIR_W'(mat.data.m02);
        s12 = PAIR_W'(mat.data.m12) + PAIR_W'(mat.data.m21);
    end

    // route pairs to output slots
    always_comb
    begin
        job.pick = pick;
        job.s    = s_full[S_W-1:0];
        job.pr   = '0;
        case (pick)
            PICK_W:
            begin
                job.pr[0] = d12;
                job.pr[1] = d20;
                job.pr[2] = d01;
            end
            PICK_X:
            begin
                job.pr[1] = s01;
                job.pr[2] = s02;
                job.pr[3] = d12;
            end
            PICK_Y:
            begin
                job.pr[0] = s01;
                job.pr[2] = s12;
                job.pr[3] = d20;
            end
            PICK_Z:
            begin
                job.pr[0] = s02;
                job.pr[1] = s12;
                job.pr[3] = d01;
            end
            default:
            begin
                job.pr = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/rmq_queue.sv @@
// ----------------------------------------------------------------------------
// rmq_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rmq_queue
    import rmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    job_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full   = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
`endif

endmodule

@@ rtl/core/rmq_back.sv @@
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, reciprocal division, scaling and saturation.
// One bit of root per stage, one quotient bit per stage, then multiply.
// ----------------------------------------------------------------------------
module rmq_back
    import rmq_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  job_t head,
    output logic pop,
    rmq_out_if.source quat
);

    localparam int NUM_W  = COEF_WIDTH + 13;     // 2^(CW+12) plus rounding term
    localparam int DV_R_W = BIGV_W + 1;         // division partial remainder
    localparam int PROD_W = PAIR_W + COEF_WIDTH;
    localparam int RND_W  = PROD_W + 1;

    logic adv;

    // whole pipeline moves unless the result register is stuck
    assign adv = !quat.valid || quat.ready;
    assign pop = adv;

    // ---------------- square root section ----------------
    logic                   sq_v   [ROOT_W+1];
    job_t                   sq_job [ROOT_W+1];
    logic [ROOT_W-1:0]      sq_q   [ROOT_W+1];
    logic [SQ_REM_W-1:0]    sq_r   [ROOT_W+1];

    assign sq_v[0]   = !q_empty;
    assign sq_job[0] = head;
    assign sq_q[0]   = '0;
    assign sq_r[0]   = '0;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sq
        localparam int B = ROOT_W - 1 - k;
        logic [2*ROOT_W-1:0] n;
        logic [SQ_REM_W-1:0] r_sh, t;
        logic                ge;

        // restoring step: bring in two bits, try (q<<2)|1
        always_comb
        begin
            n    = {1'b0, sq_job[k].s, 14'b0};
            r_sh = {sq_r[k][SQ_REM_W-3:0], n[2*B+1 -: 2]};
            t    = SQ_REM_W'({sq_q[k], 2'b01});
            ge   = (r_sh >= t);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_job[k+1] <= sq_job[k];
                sq_r[k+1]   <= ge ? (r_sh - t) : r_sh;
                sq_q[k+1]   <= {sq_q[k][ROOT_W-2:0], ge};
            end
        end
    end

    // ---------------- reciprocal division section ----------------
    logic                   dv_v   [COEF_WIDTH+1];
    job_t                   dv_job [COEF_WIDTH+1];
    logic [BIGV_W-1:0]      dv_d   [COEF_WIDTH+1];
    logic [NUM_W-1:0]       dv_num [COEF_WIDTH+1];
    logic [DV_R_W-1:0]      dv_rem [COEF_WIDTH+1];
    logic [COEF_WIDTH-1:0]  dv_quo [COEF_WIDTH+1];
    logic [ROOT_W:0]        root_inc;

    // rounded root and numerator
    always_comb
    begin
        root_inc  = {1'b0, sq_q[ROOT_W]} + (ROOT_W+1)'(1);
        dv_d[0]   = root_inc[ROOT_W:1];
        dv_num[0] = (NUM_W'(1) << (COEF_WIDTH + 12)) + NUM_W'(dv_d[0] >> 1);
        dv_rem[0] = DV_R_W'(dv_num[0][NUM_W-1:COEF_WIDTH]);
        dv_quo[0] = '0;
    end
    assign dv_v[0]   = sq_v[ROOT_W];
    assign dv_job[0] = sq_job[ROOT_W];

    for (genvar j = 0; j < COEF_WIDTH; j++)
    begin : g_dv
        localparam int B = COEF_WIDTH - 1 - j;
        logic [DV_R_W-1:0] rs, dd;
        logic              ge;

        // restoring step: one quotient bit
        always_comb
        begin
            rs = {dv_rem[j][DV_R_W-2:0], dv_num[j][B]};
            dd = DV_R_W'(dv_d[j]);
            ge = (rs >= dd);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v[j+1] <= dv_v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_job[j+1] <= dv_job[j];
                dv_d[j+1]   <= dv_d[j];
                dv_num[j+1] <= dv_num[j];
                dv_rem[j+1] <= ge ? (rs - dd) : rs;
                dv_quo[j+1] <= {dv_quo[j][COEF_WIDTH-2:0], ge};
            end
        end
    end

    // ---------------- multiply stage ----------------
    logic                    mu_v_reg;
    pick_t                   mu_pick_reg;
    logic [BIGV_W-1:0]       mu_bigv_reg;
    logic [COEF_WIDTH-1:0]   mu_coef_reg;
    logic [3:0]              mu_neg_reg;
    logic [3:0][PROD_W-1:0]  mu_prod_reg;
    logic [3:0]              neg;
    logic [3:0][PAIR_W-1:0]  mag;

    // magnitude of each pair
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = dv_job[COEF_WIDTH].pr[i][PAIR_W-1];
            mag[i] = neg[i] ? (~dv_job[COEF_WIDTH].pr[i] + PAIR_W'(1))
                            : dv_job[COEF_WIDTH].pr[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            mu_v_reg <= dv_v[COEF_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_pick_reg <= dv_job[COEF_WIDTH].pick;
            mu_bigv_reg <= dv_d[COEF_WIDTH];
            mu_coef_reg <= dv_quo[COEF_WIDTH];
            mu_neg_reg  <= neg;
            for (int i = 0; i < 4; i++)
            begin
                mu_prod_reg[i] <= PROD_W'(mag[i]) * PROD_W'(dv_quo[COEF_WIDTH]);
            end
        end
    end

    // ---------------- round, saturate, result register ----------------
    logic                    out_v_reg;
    quat_t                   out_data_reg;
    logic [3:0][DATA_W-1:0]  comp;
    logic [RND_W-1:0]        rnd;
    logic [RND_W-COEF_WIDTH-1:0] qm;
    logic [1:0]              rslot;

    always_comb
    begin
        rslot = root_slot(mu_pick_reg);
        rnd   = '0;
        qm    = '0;
        for (int i = 0; i < 4; i++)
        begin
            rnd = RND_W'(mu_prod_reg[i]) + (RND_W'(1) << (COEF_WIDTH - 1));
            qm  = rnd[RND_W-1:COEF_WIDTH];
            if (mu_neg_reg[i])
            begin
                if (qm > (RND_W-COEF_WIDTH)'(Q_NEG_MAG))
                begin
                    comp[i] = DATA_W'(Q_NEG_MAG);
                end
                else
                begin
                    comp[i] = ~qm[DATA_W-1:0] + DATA_W'(1);
                end
            end
            else
            begin
                if (qm > (RND_W-COEF_WIDTH)'(Q_MAX))
                begin
                    comp[i] = DATA_W'(Q_MAX);
                end
                else
                begin
                    comp[i] = qm[DATA_W-1:0];
                end
            end
            if (rslot == 2'(i))
            begin
                comp[i] = DATA_W'(mu_bigv_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= mu_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.qx <= comp[0];
            out_data_reg.qy <= comp[1];
            out_data_reg.qz <= comp[2];
            out_data_reg.qw <= comp[3];
        end
    end

    assign quat.valid = out_v_reg;
    assign quat.data  = out_data_reg;

`ifndef SYNTH
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        mu_v_reg |-> (mu_bigv_reg >= BIGV_W'(8192)) && (mu_bigv_reg <= BIGV_W'(21678)))
        else $error("rounded root out of range");
    a_coef_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mu_v_reg |-> (mu_coef_reg != '0))
        else $error("reciprocal coefficient is zero");
`endif

endmodule
